// ===== src/rcptm_pkg.sv =====
// Shared types, register map and constants for the RC pulse capture tank mixer.
`default_nettype none

package rcptm_pkg;

  localparam int unsigned WIDTH_W = 16;
  localparam int unsigned DUTY_W = 8;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned REG_IDX_W = 2;

  localparam int unsigned DUTY_LIMIT_DEF = 510;

  localparam logic [REG_IDX_W-1:0] REG_STEERING_CENTER = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_THROTTLE_CENTER = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COUNTER_TOP = 2'd2;

  localparam logic [WIDTH_W-1:0] STEERING_CENTER_RST = 16'd1500;
  localparam logic [WIDTH_W-1:0] THROTTLE_CENTER_RST = 16'd1500;
  localparam logic [WIDTH_W-1:0] COUNTER_TOP_RST = 16'hFF00;

  typedef struct packed {
    logic steer_pin;
    logic throttle_pin;
  } in_beat_t;

  typedef struct packed {
    logic [DUTY_W-1:0] motor_a_duty;
    logic              motor_a_reverse;
    logic [DUTY_W-1:0] motor_b_duty;
    logic              motor_b_reverse;
  } out_beat_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] steering_center;
    logic [WIDTH_W-1:0] throttle_center;
    logic [WIDTH_W-1:0] counter_top;
  } cfg_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] steer_width;
    logic [WIDTH_W-1:0] throttle_width;
  } widths_t;

endpackage

`default_nettype wire

// ===== src/rcptm_cfg.sv =====
// APB configuration registers: steering center, throttle center, counter top.
`default_nettype none

module rcptm_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rcptm_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [rcptm_pkg::PDATA_W-1:0]   pwdata,
  output logic      [rcptm_pkg::PDATA_W-1:0]   prdata,
  output logic                                 pready,
  output rcptm_pkg::cfg_t                      cfg
);
  import rcptm_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.steering_center <= STEERING_CENTER_RST;
      cfg.throttle_center <= THROTTLE_CENTER_RST;
      cfg.counter_top     <= COUNTER_TOP_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_STEERING_CENTER: cfg.steering_center <= pwdata[WIDTH_W-1:0];
        REG_THROTTLE_CENTER: cfg.throttle_center <= pwdata[WIDTH_W-1:0];
        REG_COUNTER_TOP:     cfg.counter_top     <= pwdata[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_STEERING_CENTER: prdata = PDATA_W'(cfg.steering_center);
      REG_THROTTLE_CENTER: prdata = PDATA_W'(cfg.throttle_center);
      REG_COUNTER_TOP:     prdata = PDATA_W'(cfg.counter_top);
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/rcptm_capture.sv =====
// Tick counter and pulse width capture, with the width stage register.
`default_nettype none

module rcptm_capture (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire rcptm_pkg::cfg_t       cfg,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire rcptm_pkg::in_beat_t   in_data,
  output logic                       wid_valid,
  input  wire logic                  wid_ready,
  output rcptm_pkg::widths_t         wid
);
  import rcptm_pkg::*;

  logic [WIDTH_W-1:0] tick_count, tick_count_next;
  logic [WIDTH_W-1:0] steer_start, steer_start_next;
  logic [WIDTH_W-1:0] throttle_start, throttle_start_next;
  logic               steer_in_pulse, steer_in_pulse_next;
  logic               throttle_in_pulse, throttle_in_pulse_next;
  logic               rearm_counter, rearm_counter_next;
  logic [WIDTH_W-1:0] steer_width, steer_width_next;
  logic [WIDTH_W-1:0] throttle_width, throttle_width_next;
  logic [1:0]         previous_pins;
  logic [1:0]         pins;
  logic [WIDTH_W-1:0] tick_cap;
  logic               accept;

  assign in_ready = !wid_valid || wid_ready;
  assign accept   = in_valid && in_ready;
  assign pins     = {in_data.steer_pin, in_data.throttle_pin};

  // capture runs steering then throttle; a rise may zero the count seen by throttle
  always_comb begin
    tick_cap               = tick_count;
    rearm_counter_next     = rearm_counter;
    steer_start_next       = steer_start;
    throttle_start_next    = throttle_start;
    steer_in_pulse_next    = steer_in_pulse;
    throttle_in_pulse_next = throttle_in_pulse;
    steer_width_next       = steer_width;
    throttle_width_next    = throttle_width;
    if (pins != previous_pins) begin
      if (!in_data.steer_pin) begin
        if (steer_in_pulse) begin
          if (steer_start < tick_cap) begin
            steer_width_next = tick_cap - steer_start;
          end
          steer_in_pulse_next = 1'b0;
        end
      end else begin
        if (rearm_counter_next) begin
          tick_cap           = '0;
          rearm_counter_next = 1'b0;
        end
        if (!steer_in_pulse) begin
          steer_start_next    = tick_cap;
          steer_in_pulse_next = 1'b1;
        end
      end
      if (!in_data.throttle_pin) begin
        if (throttle_in_pulse) begin
          if (throttle_start < tick_cap) begin
            throttle_width_next = tick_cap - throttle_start;
          end
          throttle_in_pulse_next = 1'b0;
        end
      end else begin
        if (rearm_counter_next) begin
          tick_cap           = '0;
          rearm_counter_next = 1'b0;
        end
        if (!throttle_in_pulse) begin
          throttle_start_next    = tick_cap;
          throttle_in_pulse_next = 1'b1;
        end
      end
      if (!in_data.steer_pin && !in_data.throttle_pin) begin
        rearm_counter_next = 1'b1;
      end
    end
    if (tick_cap >= cfg.counter_top) begin
      tick_count_next = '0;
    end else begin
      tick_count_next = tick_cap + WIDTH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count        <= '0;
      steer_start       <= '0;
      throttle_start    <= '0;
      steer_in_pulse    <= 1'b0;
      throttle_in_pulse <= 1'b0;
      rearm_counter     <= 1'b1;
      steer_width       <= '0;
      throttle_width    <= '0;
      previous_pins     <= '0;
    end else if (accept) begin
      tick_count        <= tick_count_next;
      steer_start       <= steer_start_next;
      throttle_start    <= throttle_start_next;
      steer_in_pulse    <= steer_in_pulse_next;
      throttle_in_pulse <= throttle_in_pulse_next;
      rearm_counter     <= rearm_counter_next;
      steer_width       <= steer_width_next;
      throttle_width    <= throttle_width_next;
      previous_pins     <= pins;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wid_valid <= 1'b0;
    end else if (in_ready) begin
      wid_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wid.steer_width    <= steer_width_next;
      wid.throttle_width <= throttle_width_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/rcptm_mixer.sv =====
// Differential drive mix of the widths into two motor commands, with result register.
`default_nettype none

module rcptm_mixer #(
  parameter int unsigned DUTY_LIMIT = rcptm_pkg::DUTY_LIMIT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire rcptm_pkg::cfg_t       cfg,
  input  wire logic                  wid_valid,
  output logic                       wid_ready,
  input  wire rcptm_pkg::widths_t    wid,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output rcptm_pkg::out_beat_t       out_data
);
  import rcptm_pkg::*;

  localparam int unsigned MIX_W = WIDTH_W + 2;
  localparam logic [MIX_W-2:0] LIMIT = (MIX_W-1)'(DUTY_LIMIT);
  localparam logic [WIDTH_W-1:0] DUTY_MAX = WIDTH_W'((1 << DUTY_W) - 1);

  logic signed [MIX_W-1:0] steer_err;
  logic signed [MIX_W-1:0] err_a;
  logic signed [MIX_W-1:0] err_b;
  logic signed [MIX_W-1:0] tw;
  logic signed [MIX_W-1:0] tc;
  logic [DUTY_W:0]         drv_a;
  logic [DUTY_W:0]         drv_b;

  // returns {reverse, duty}
  function automatic logic [DUTY_W:0] drive(input logic signed [MIX_W-1:0] err);
    logic [MIX_W-1:0]   neg;
    logic [MIX_W-2:0]   mag;
    logic [WIDTH_W-1:0] half;
    logic [DUTY_W-1:0]  duty;
    neg  = MIX_W'(-err);
    mag  = err[MIX_W-1] ? neg[MIX_W-2:0] : err[MIX_W-2:0];
    if (mag > LIMIT) begin
      mag = LIMIT;
    end
    half = mag[MIX_W-2:1];
    duty = (half > DUTY_MAX) ? DUTY_MAX[DUTY_W-1:0] : half[DUTY_W-1:0];
    return {err[MIX_W-1], duty};
  endfunction

  assign tw        = $signed({2'b00, wid.throttle_width});
  assign tc        = $signed({2'b00, cfg.throttle_center});
  assign steer_err = $signed({2'b00, wid.steer_width}) - $signed({2'b00, cfg.steering_center});
  assign err_a     = tw + steer_err - tc;
  assign err_b     = tw - steer_err - tc;
  assign drv_a     = drive(err_a);
  assign drv_b     = drive(err_b);

  assign wid_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wid_ready) begin
      out_valid <= wid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wid_valid && wid_ready) begin
      out_data.motor_a_reverse <= drv_a[DUTY_W];
      out_data.motor_a_duty    <= drv_a[DUTY_W-1:0];
      out_data.motor_b_reverse <= drv_b[DUTY_W];
      out_data.motor_b_duty    <= drv_b[DUTY_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/rc_pulse_capture_tank_mixer.sv =====
// Top level: RC pulse capture feeding a differential drive mixer.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------
//   in       | in_valid / in_ready  | in_data   (steer_pin, throttle_pin)
//   out      | out_valid / out_ready| out_data  (motor A/B duty, reverse)
//   config   | APB psel / penable   | paddr, pwdata, prdata (3 regs)
//
// One beat in and one beat out per cycle while the output is not stalled; a beat's
// result passes the capture register, then the result register.
// Synchronous reset clears counter, capture state and both valid flags; the
// counter is zeroed again at the first rising pin after both pins were low.
// A stalled output holds its beat; the width register keeps taking beats
// until both stages are full.
`default_nettype none

module rc_pulse_capture_tank_mixer #(
  parameter int unsigned DUTY_LIMIT = rcptm_pkg::DUTY_LIMIT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire rcptm_pkg::in_beat_t             in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output rcptm_pkg::out_beat_t                 out_data,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rcptm_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [rcptm_pkg::PDATA_W-1:0]   pwdata,
  output logic      [rcptm_pkg::PDATA_W-1:0]   prdata,
  output logic                                 pready
);
  import rcptm_pkg::*;

  cfg_t    cfg;
  widths_t wid;
  logic    wid_valid;
  logic    wid_ready;

  rcptm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rcptm_capture u_capture (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .wid_valid (wid_valid),
    .wid_ready (wid_ready),
    .wid       (wid)
  );

  rcptm_mixer #(
    .DUTY_LIMIT (DUTY_LIMIT)
  ) u_mixer (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .wid_valid (wid_valid),
    .wid_ready (wid_ready),
    .wid       (wid),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== src/rcptm_checker.sv =====
// Port-level checks for the RC pulse capture tank mixer, bound to the top level.
`default_nettype none

module rcptm_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire rcptm_pkg::out_beat_t  out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("accepted beat did not reach the output");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

endmodule

bind rc_pulse_capture_tank_mixer rcptm_checker u_rcptm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/rc_pulse_capture_tank_mixer_tb.sv =====
// Testbench for the RC pulse capture tank mixer: pin-sample beats in, motor commands checked.
module rc_pulse_capture_tank_mixer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rcptm_pkg::*;

  localparam int DUTY_CAP = DUTY_LIMIT_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {CH_STEER = 0, CH_THROTTLE = 1} chan_e;

  class motor_mix_board;
    logic [WIDTH_W-1:0] steer_ctr = STEERING_CENTER_RST;
    logic [WIDTH_W-1:0] thr_ctr = THROTTLE_CENTER_RST;
    logic [WIDTH_W-1:0] top = COUNTER_TOP_RST;
    logic [WIDTH_W-1:0] tick = '0;
    logic [WIDTH_W-1:0] start_cnt [2] = '{16'd0, 16'd0};
    logic [WIDTH_W-1:0] width_cnt [2] = '{16'd0, 16'd0};
    bit in_pulse [2] = '{1'b0, 1'b0};
    bit rearm = 1'b1;
    logic [1:0] prev_pins = '0;
    out_beat_t motor_cmds_due [$];
    int errors = 0;

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [WIDTH_W-1:0] val);
      case (idx)
        REG_STEERING_CENTER: steer_ctr = val;
        REG_THROTTLE_CENTER: thr_ctr = val;
        REG_COUNTER_TOP: top = val;
        default: ;
      endcase
    endfunction

    function void capture(chan_e ch, bit level);
      if (!level) begin
        if (in_pulse[ch]) begin
          if (start_cnt[ch] < tick) width_cnt[ch] = tick - start_cnt[ch];
          in_pulse[ch] = 1'b0;
        end
      end else begin
        if (rearm) begin
          tick = '0;
          rearm = 1'b0;
        end
        if (!in_pulse[ch]) begin
          start_cnt[ch] = tick;
          in_pulse[ch] = 1'b1;
        end
      end
    endfunction

    // {duty, reverse}
    function logic [DUTY_W:0] motor_cmd(int mixed);
      int err;
      int mag;
      err = mixed - int'(thr_ctr);
      mag = (err < 0) ? -err : err;
      if (mag > DUTY_CAP) mag = DUTY_CAP;
      mag = mag >> 1;
      if (mag > 255) mag = 255;
      return {mag[DUTY_W-1:0], err < 0};
    endfunction

    function void note_tick(in_beat_t b);
      logic [1:0] pins;
      int steer_err;
      out_beat_t cmd;
      pins = {b.steer_pin, b.throttle_pin};
      if (pins != prev_pins) begin
        capture(CH_STEER, b.steer_pin);
        capture(CH_THROTTLE, b.throttle_pin);
        if (!b.steer_pin && !b.throttle_pin) rearm = 1'b1;
      end
      prev_pins = pins;
      if (tick >= top) tick = '0;
      else tick = tick + 16'd1;
      steer_err = int'(width_cnt[CH_STEER]) - int'(steer_ctr);
      {cmd.motor_a_duty, cmd.motor_a_reverse} = motor_cmd(int'(width_cnt[CH_THROTTLE]) + steer_err);
      {cmd.motor_b_duty, cmd.motor_b_reverse} = motor_cmd(int'(width_cnt[CH_THROTTLE]) - steer_err);
      motor_cmds_due.push_back(cmd);
    endfunction

    function void check_motor(out_beat_t got);
      out_beat_t exp;
      if (motor_cmds_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected motor beat: a=%0d/%0b b=%0d/%0b", got.motor_a_duty,
                   got.motor_a_reverse, got.motor_b_duty, got.motor_b_reverse);
        return;
      end
      exp = motor_cmds_due.pop_front();
      if (got.motor_a_duty !== exp.motor_a_duty || got.motor_a_reverse !== exp.motor_a_reverse ||
          got.motor_b_duty !== exp.motor_b_duty || got.motor_b_reverse !== exp.motor_b_reverse) begin
        errors++;
        if (errors <= 10)
          $display("motor mismatch: exp a=%0d/%0b b=%0d/%0b got a=%0d/%0b b=%0d/%0b",
                   exp.motor_a_duty, exp.motor_a_reverse, exp.motor_b_duty, exp.motor_b_reverse,
                   got.motor_a_duty, got.motor_a_reverse, got.motor_b_duty, got.motor_b_reverse);
      end
    endfunction

    function int pending();
      return motor_cmds_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  motor_mix_board board = new();
  bit quiet = 1'b0;
  int stall_left = 0;
  int cycles = 0;
  int ticks_sent = 0;

  rc_pulse_capture_tank_mixer u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_tick(in_data);
      if (out_valid && out_ready) board.check_motor(out_data);
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // entered and left just after a falling edge
  task automatic send_tick(in_beat_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic send_pins(logic [1:0] p);
    send_tick(in_beat_t'(p));
  endtask

  task automatic send_frame(int lead, int s_off, int s_len, int t_off, int t_len);
    int total;
    in_beat_t b;
    total = lead + (s_off + s_len > t_off + t_len ? s_off + s_len : t_off + t_len) + 1;
    for (int i = 0; i < total; i++) begin
      b.steer_pin = (i >= lead + s_off) && (i < lead + s_off + s_len);
      b.throttle_pin = (i >= lead + t_off) && (i < lead + t_off + t_len);
      send_tick(b);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [WIDTH_W-1:0] val);
    logic [PDATA_W-1:0] word;
    word = {16'($urandom_range(0, 65535)), val};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, word[WIDTH_W-1:0]);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(int n_items);
    int stop_at;
    int n;
    stop_at = ticks_sent + n_items;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 99) < 80) begin
        send_frame($urandom_range(1, 6), $urandom_range(0, 8), $urandom_range(1, 35),
                   $urandom_range(0, 8), $urandom_range(1, 35));
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) send_pins(2'($urandom_range(0, 3)));
      end
    end
  endtask

  initial begin
    logic [1:0] seq_reset [11] = '{2'b00, 2'b10, 2'b11, 2'b11, 2'b01, 2'b00,
                                   2'b01, 2'b11, 2'b10, 2'b00, 2'b00};
    logic [1:0] seq_wrap [9] = '{2'b10, 2'b10, 2'b10, 2'b10, 2'b10, 2'b00,
                                 2'b11, 2'b01, 2'b00};
    logic [1:0] seq_stuck [5] = '{2'b10, 2'b11, 2'b00, 2'b01, 2'b00};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: widths far below center, duty saturates
    foreach (seq_reset[i]) send_pins(seq_reset[i]);
    settle();
    // tiny top wraps mid-pulse; centers at their extremes
    write_reg(REG_COUNTER_TOP, 16'd2);
    write_reg(REG_STEERING_CENTER, 16'd0);
    write_reg(REG_THROTTLE_CENTER, 16'hFFFF);
    write_reg(REG_UNUSED, 16'd7);
    foreach (seq_wrap[i]) send_pins(seq_wrap[i]);
    settle();
    // top of zero holds the counter, so no width updates
    write_reg(REG_COUNTER_TOP, 16'd0);
    foreach (seq_stuck[i]) send_pins(seq_stuck[i]);
    settle();

    for (int ph = 0; ph < 5; ph++) begin
      quiet = 1'b0;
      case (ph)
        0: begin
          quiet = 1'b1;
          write_reg(REG_STEERING_CENTER, 16'd15);
          write_reg(REG_THROTTLE_CENTER, 16'd15);
          write_reg(REG_COUNTER_TOP, 16'hFFFF);
        end
        1: begin
          write_reg(REG_STEERING_CENTER, 16'($urandom_range(0, 40)));
          write_reg(REG_THROTTLE_CENTER, 16'($urandom_range(0, 40)));
          write_reg(REG_COUNTER_TOP, 16'($urandom_range(8, 60)));
        end
        2: begin
          write_reg(REG_STEERING_CENTER, 16'd0);
          write_reg(REG_THROTTLE_CENTER, 16'hFFFF);
          write_reg(REG_COUNTER_TOP, 16'($urandom_range(30, 200)));
        end
        3: begin
          write_reg(REG_STEERING_CENTER, 16'hFFFF);
          write_reg(REG_THROTTLE_CENTER, 16'd0);
          write_reg(REG_COUNTER_TOP, 16'd1);
        end
        default: begin
          write_reg(REG_STEERING_CENTER, 16'($urandom_range(0, 65535)));
          write_reg(REG_THROTTLE_CENTER, 16'($urandom_range(5, 30)));
          write_reg(REG_COUNTER_TOP, 16'($urandom_range(1, 65535)));
        end
      endcase
      run_phase(100);
      settle();
    end

    repeat (10) @(posedge clk);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
